// ----- hw/rtl/kpi_pkg.sv -----
`default_nettype none
package kpi_pkg;

  localparam int MAX_KEYS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Full and half turn in Q16.16 degrees
  localparam logic [32:0] ONE_TURN  = 33'd23592960;
  localparam logic [32:0] HALF_TURN = 33'd11796480;
  // 92 turns: lifts any 32-bit angle to a non-negative value
  localparam logic [32:0] WRAP_BIAS = 33'd2170552320;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [63:0] time_req;
    logic signed [31:0] pupil_x;
    logic signed [31:0] pupil_y;
    logic signed [31:0] pupil_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] vert_angle;
    logic signed [31:0] horiz_angle;
    logic signed [31:0] roll_deg;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] out_time;
    logic signed [31:0] out_pupil_x;
    logic signed [31:0] out_pupil_y;
    logic signed [31:0] out_pupil_z;
    logic signed [31:0] out_target_x;
    logic signed [31:0] out_target_y;
    logic signed [31:0] out_target_z;
    logic signed [31:0] out_vert_angle;
    logic signed [31:0] out_horiz_angle;
    logic signed [31:0] out_roll_deg;
  } rsp_t;

  // Value order: pupil xyz, target xyz, vertical, horizontal, roll
  typedef logic [8:0][31:0] vals_t;

  typedef struct packed {
    logic [63:0] stamp;
    vals_t       val;
  } key_t;

  localparam int KEY_BITS = $bits(key_t);

  function automatic key_t item_to_key(req_t r);
    key_t k;
    k.stamp  = r.time_req;
    k.val[0] = r.pupil_x;
    k.val[1] = r.pupil_y;
    k.val[2] = r.pupil_z;
    k.val[3] = r.target_x;
    k.val[4] = r.target_y;
    k.val[5] = r.target_z;
    k.val[6] = r.vert_angle;
    k.val[7] = r.horiz_angle;
    k.val[8] = r.roll_deg;
    return k;
  endfunction

  function automatic rsp_t vals_to_rsp(logic [1:0] st, logic [63:0] t, vals_t v);
    rsp_t r;
    r.status          = st;
    r.out_time        = t;
    r.out_pupil_x     = v[0];
    r.out_pupil_y     = v[1];
    r.out_pupil_z     = v[2];
    r.out_target_x    = v[3];
    r.out_target_y    = v[4];
    r.out_target_z    = v[5];
    r.out_vert_angle  = v[6];
    r.out_horiz_angle = v[7];
    r.out_roll_deg    = v[8];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/kpi_ram.sv -----
`default_nettype none
module kpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/keyframe_pose_interpolator.sv -----
`default_nettype none
// Keyframe pose interpolator: holds up to MAX_KEYS keyframes sorted by signed
// 64-bit time in one single-port-read RAM. Insert (action 0) walks the table
// key by key (read, then compare) to find its place, then shifts the later
// keys up one by one (read, then write); an equal time overwrites, a full
// table drops (status 2). Query (action 1) walks the table the same way;
// outside the stored span it returns the end key unchanged, inside it runs a
// restoring divide for the weight, reduces both rolls modulo 360, and uses
// one shared multiplier for the nine blends. Clear (action 2) empties the
// table; unknown actions leave it as it is. The block takes one transaction
// at a time; a finished result may wait in the output register while the
// next request is taken.
module keyframe_pose_interpolator import kpi_pkg::*; #(
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int WW = FRAC_BITS + 1;
  localparam int DW = $clog2(FRAC_BITS);
  localparam int PW = 32 + WW;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_KEYS);
  localparam logic [WW-1:0] W_ONE    = WW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] P_HALF   = PW'(1) << (FRAC_BITS - 1);
  localparam logic [DW-1:0] DIV_LAST = DW'(FRAC_BITS - 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_RD   = 12'b000000000010,
    S_CMP  = 12'b000000000100,
    S_SHRD = 12'b000000001000,
    S_SHWR = 12'b000000010000,
    S_WR   = 12'b000000100000,
    S_DSET = 12'b000001000000,
    S_DIV  = 12'b000010000000,
    S_WRAP = 12'b000100000000,
    S_UNW  = 12'b001000000000,
    S_MUL  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  state_t state;
  logic [CW-1:0] count, j, idx, k;
  logic          is_new;
  req_t          item;
  key_t          prev_key, cur_key, rdata, wkey;
  logic [63:0]   e_reg, r_reg, rem;
  logic [WW-1:0] q;
  logic [DW-1:0] dcnt;
  logic [32:0]   u;
  logic [2:0]    wstep;
  logic          wsel;
  logic signed [32:0] ra, rb;
  logic [3:0]    vi;
  logic          phase;
  logic [PW-1:0] acc;
  vals_t         bl;
  logic [1:0]    st;
  logic [63:0]   res_time;

  logic          we;
  logic [AW-1:0] waddr, raddr;

  kpi_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_KEYS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wkey),
    .raddr(raddr), .rdata(rdata)
  );

  assign req_ready = (state == S_IDLE);

  // RAM port steering
  always_comb begin
    we    = 1'b0;
    waddr = k[AW-1:0];
    wkey  = rdata;
    raddr = j[AW-1:0];
    unique case (state)
      S_SHRD: raddr = k[AW-1:0] - AW'(1);
      S_SHWR: we = 1'b1;
      S_WR: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wkey  = item_to_key(item);
      end
      default: ;
    endcase
  end

  // Scan compare
  logic [CW-1:0] last_idx;
  logic          ge, eq, is_last;
  assign last_idx = count - CW'(1);
  assign ge       = $signed(rdata.stamp) >= item.time_req;
  assign eq       = rdata.stamp == item.time_req;
  assign is_last  = j == last_idx;

  // Divide step
  logic [64:0] rem2;
  logic        dbit;
  assign rem2 = {rem, 1'b0};
  assign dbit = rem2 >= {1'b0, r_reg};

  // Modulo step
  logic [32:0] mval, u_next;
  assign mval   = ONE_TURN << wstep;
  assign u_next = (u >= mval) ? u - mval : u;

  // Shared multiplier
  logic [31:0]   va, vb, ua, ub;
  logic [WW-1:0] w1;
  logic [PW-1:0] prod, sum;
  logic [31:0]   bval;
  always_comb begin
    va = prev_key.val[vi];
    vb = cur_key.val[vi];
    if (vi == 4'd8) begin
      va = ra[31:0];
      vb = rb[31:0];
    end
  end
  assign ua   = {~va[31], va[30:0]};
  assign ub   = {~vb[31], vb[30:0]};
  assign w1   = W_ONE - q;
  assign prod = phase ? PW'(ub) * PW'(q) : PW'(ua) * PW'(w1);
  assign sum  = acc + prod;
  assign bval = sum[FRAC_BITS +: 32];

  // Output register load
  logic out_load;
  assign out_load = (state == S_OUT) && (!rsp_valid || rsp_ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            item     <= req;
            j        <= '0;
            bl       <= '0;
            res_time <= (req.action == ACT_QUERY && count != '0) ? req.time_req : '0;
            st       <= (req.action == ACT_QUERY && count == '0) ? ST_EMPTY : ST_OK;
            case (req.action)
              ACT_INSERT: begin
                if (count == '0) begin
                  idx    <= '0;
                  is_new <= 1'b1;
                  state  <= S_WR;
                end else begin
                  state <= S_RD;
                end
              end
              ACT_QUERY: state <= (count == '0) ? S_OUT : S_RD;
              ACT_CLEAR: begin
                count <= '0;
                state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (item.action == ACT_INSERT) begin
            if (ge && eq) begin
              idx    <= j;
              is_new <= 1'b0;
              state  <= S_WR;
            end else if (ge || is_last) begin
              if (count == FULL_CNT) begin
                st    <= ST_FULL;
                state <= S_OUT;
              end else begin
                idx    <= ge ? j : count;
                is_new <= 1'b1;
                k      <= count;
                state  <= (ge && count > j) ? S_SHRD : S_WR;
              end
            end else begin
              j     <= j + CW'(1);
              state <= S_RD;
            end
          end else begin
            if (ge) begin
              if (j == '0 || (is_last && eq)) begin
                bl    <= rdata.val;
                state <= S_OUT;
              end else begin
                cur_key <= rdata;
                e_reg   <= item.time_req - prev_key.stamp;
                r_reg   <= rdata.stamp - prev_key.stamp;
                state   <= S_DSET;
              end
            end else if (is_last) begin
              bl    <= rdata.val;
              state <= S_OUT;
            end else begin
              prev_key <= rdata;
              j        <= j + CW'(1);
              state    <= S_RD;
            end
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          k     <= k - CW'(1);
          state <= (k - CW'(1) > idx) ? S_SHRD : S_WR;
        end
        S_WR: begin
          if (is_new) begin
            count <= count + CW'(1);
          end
          state <= S_OUT;
        end
        S_DSET: begin
          rem   <= e_reg;
          dcnt  <= '0;
          u     <= WRAP_BIAS + {prev_key.val[8][31], prev_key.val[8]};
          wstep <= 3'd7;
          wsel  <= 1'b0;
          if (e_reg >= r_reg) begin
            q     <= W_ONE;
            state <= S_WRAP;
          end else begin
            q     <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= dbit ? rem2[63:0] - r_reg : rem2[63:0];
          q    <= {q[WW-2:0], dbit};
          dcnt <= dcnt + DW'(1);
          if (dcnt == DIV_LAST) begin
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (wstep == 3'd0) begin
            if (!wsel) begin
              ra    <= u_next;
              wsel  <= 1'b1;
              u     <= WRAP_BIAS + {cur_key.val[8][31], cur_key.val[8]};
              wstep <= 3'd7;
            end else begin
              u     <= u_next;
              rb    <= u_next;
              state <= S_UNW;
            end
          end else begin
            u     <= u_next;
            wstep <= wstep - 3'd1;
          end
        end
        S_UNW: begin
          // Unwrap across the half turn: pull the larger angle down one turn
          if (ra - rb > $signed(HALF_TURN) || rb - ra > $signed(HALF_TURN)) begin
            if (ra > rb) begin
              ra <= ra - $signed(ONE_TURN);
            end else begin
              rb <= rb - $signed(ONE_TURN);
            end
          end
          vi    <= '0;
          phase <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: begin
          phase <= ~phase;
          if (!phase) begin
            acc <= prod + P_HALF;
          end else begin
            bl[vi] <= {~bval[31], bval[30:0]};
            vi     <= vi + 4'd1;
            if (vi == 4'd8) begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            rsp   <= vals_to_rsp(st, res_time, bl);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("key count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.action == ACT_CLEAR |=> count == '0)
    else $error("clear left keys in table");

  a_weight: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> q <= W_ONE) else $error("blend weight above one");

  a_full: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && st == ST_FULL |-> count == FULL_CNT)
    else $error("drop flagged with room left");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    state == S_SHWR |-> k > idx && count < FULL_CNT)
    else $error("shift out of range");

endmodule
`default_nettype wire

// ----- bench/keyframe_pose_interpolator_tb.sv -----
`timescale 1ns / 100ps
module keyframe_pose_interpolator_tb;
  import kpi_pkg::*;

  localparam int     KEYS       = 64;
  localparam longint TURN       = 64'sd23592960;
  localparam longint HALF       = 64'sd11796480;
  localparam longint LIMIT      = 3000000;
  localparam int     DRAIN      = 400;
  localparam int     RAND_ITEMS = 850;
  localparam int     REQ_BITS   = $bits(req_t);
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  keyframe_pose_interpolator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // Shadow keyframe table
  int                 key_cnt;
  logic signed [63:0] key_time [KEYS];
  vals_t              key_val  [KEYS];

  rsp_t   pending_rsp[$];
  int     errors;
  longint cycles;
  bit     hold_rx;
  bit     no_gaps;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } row_t;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void add_row(row_t rw);
    rows = {rows, rw};
  endfunction

  function automatic vals_t req_vals(req_t r);
    vals_t v;
    v[0] = r.pupil_x;    v[1] = r.pupil_y;     v[2] = r.pupil_z;
    v[3] = r.target_x;   v[4] = r.target_y;    v[5] = r.target_z;
    v[6] = r.vert_angle; v[7] = r.horiz_angle; v[8] = r.roll_deg;
    return v;
  endfunction

  function automatic rsp_t pack_rsp(logic [1:0] st, logic [63:0] t, vals_t v);
    rsp_t o;
    o.status = st; o.out_time = t;
    o.out_pupil_x = v[0];    o.out_pupil_y = v[1];     o.out_pupil_z = v[2];
    o.out_target_x = v[3];   o.out_target_y = v[4];    o.out_target_z = v[5];
    o.out_vert_angle = v[6]; o.out_horiz_angle = v[7]; o.out_roll_deg = v[8];
    return o;
  endfunction

  function automatic longint mix(longint a, longint b, longint w2);
    longint s;
    s = (a + 64'sd2147483648) * (64'sd65536 - w2) + (b + 64'sd2147483648) * w2
        + 64'sd32768;
    return (s >>> 16) - 64'sd2147483648;
  endfunction

  function automatic longint mod_turn(longint a);
    longint r;
    r = a % TURN;
    if (r < 0) r += TURN;
    return r;
  endfunction

  // Apply one transaction to the shadow table and return its response
  function automatic rsp_t apply_pose_cmd(req_t r);
    vals_t       v;
    logic [63:0] elapsed, span;
    logic [79:0] num;
    longint      w2, a, b;
    int          idx, p;
    v = '0;
    case (r.action)
      ACT_INSERT: begin
        idx = 0;
        while (idx < key_cnt && key_time[idx] < r.time_req) idx++;
        if (idx < key_cnt && key_time[idx] == r.time_req) begin
          key_val[idx] = req_vals(r);
        end else if (key_cnt >= KEYS) begin
          return pack_rsp(ST_FULL, '0, v);
        end else begin
          for (int k = key_cnt; k > idx; k--) begin
            key_time[k] = key_time[k-1];
            key_val[k]  = key_val[k-1];
          end
          key_time[idx] = r.time_req;
          key_val[idx]  = req_vals(r);
          key_cnt++;
        end
        return pack_rsp(ST_OK, '0, v);
      end
      ACT_QUERY: begin
        if (key_cnt == 0) return pack_rsp(ST_EMPTY, '0, v);
        if (r.time_req <= key_time[0]) return pack_rsp(ST_OK, r.time_req, key_val[0]);
        if (r.time_req >= key_time[key_cnt-1])
          return pack_rsp(ST_OK, r.time_req, key_val[key_cnt-1]);
        idx = 1;
        while (idx < key_cnt - 1 && r.time_req > key_time[idx]) idx++;
        p = idx - 1;
        elapsed = r.time_req - key_time[p];
        span    = key_time[idx] - key_time[p];
        if (elapsed >= span) w2 = 65536;
        else begin
          num = {elapsed, 16'd0};
          w2  = longint'(num / span);
        end
        for (int j = 0; j < 8; j++)
          v[j] = 32'(mix(longint'($signed(key_val[p][j])),
                         longint'($signed(key_val[idx][j])), w2));
        // Unwrap roll across the half turn before blending
        a = mod_turn(longint'($signed(key_val[p][8])));
        b = mod_turn(longint'($signed(key_val[idx][8])));
        if (a - b > HALF || b - a > HALF) begin
          if (a > b) a -= TURN;
          else b -= TURN;
        end
        v[8] = 32'(mix(a, b, w2));
        return pack_rsp(ST_OK, r.time_req, v);
      end
      ACT_CLEAR: begin
        key_cnt = 0;
        return pack_rsp(ST_OK, '0, v);
      end
      default: return pack_rsp(ST_OK, '0, v);
    endcase
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // Receive side: random stalls, and long holds on request
  initial begin
    rsp_t w;
    int   n;
    rsp_ready = 1'b0;
    @(negedge rst);
    forever begin
      n = hold_rx ? 600 : (no_gaps ? 0 : $urandom_range(0, 4));
      hold_rx = 1'b0;
      if (n > 0) begin
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response expected none got %h", $time, rsp);
      end else begin
        w = pending_rsp.pop_front();
        check_field("status",      w.status,          rsp.status);
        check_field("out_time",    w.out_time,        rsp.out_time);
        check_field("pupil_x",     w.out_pupil_x,     rsp.out_pupil_x);
        check_field("pupil_y",     w.out_pupil_y,     rsp.out_pupil_y);
        check_field("pupil_z",     w.out_pupil_z,     rsp.out_pupil_z);
        check_field("target_x",    w.out_target_x,    rsp.out_target_x);
        check_field("target_y",    w.out_target_y,    rsp.out_target_y);
        check_field("target_z",    w.out_target_z,    rsp.out_target_z);
        check_field("vert_angle",  w.out_vert_angle,  rsp.out_vert_angle);
        check_field("horiz_angle", w.out_horiz_angle, rsp.out_horiz_angle);
        check_field("roll_deg",    w.out_roll_deg,    rsp.out_roll_deg);
      end
    end
  end

  // Offer one transaction; hold valid until accepted
  task automatic send(req_t item, bit typed, rsp_t want);
    rsp_t got;
    int   gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    got = apply_pose_cmd(item);
    pending_rsp = {pending_rsp, typed ? want : got};
  endtask

  function automatic req_t make_req(logic [1:0] act, logic [63:0] t, logic [31:0] val,
                                    logic [31:0] roll);
    req_t r;
    r.action = act; r.time_req = t;
    r.pupil_x = val;    r.pupil_y = ~val;     r.pupil_z = val;
    r.target_x = ~val;  r.target_y = val;     r.target_z = ~val;
    r.vert_angle = val; r.horiz_angle = ~val; r.roll_deg = roll;
    return r;
  endfunction

  function automatic req_t rand_req(logic [1:0] act, logic [63:0] t);
    req_t r;
    r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.action   = act;
    r.time_req = t;
    // Keep roll within two turns either way most of the time
    if ($urandom_range(0, 2) != 0)
      r.roll_deg = $signed($urandom_range(0, 1440 * 65536)) - 32'sd47185920;
    return r;
  endfunction

  function automatic logic [63:0] rand_time();
    case ($urandom_range(0, 9))
      0, 1: return {$urandom, $urandom};
      2: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      default: return 64'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [63:0] query_time();
    int          p;
    logic [63:0] d;
    if (key_cnt < 2 || $urandom_range(0, 4) == 0) return rand_time();
    p = $urandom_range(0, key_cnt - 2);
    if ($urandom_range(0, 5) == 0) return key_time[p + $urandom_range(0, 1)];
    d = key_time[p+1] - key_time[p];
    return key_time[p] + ({$urandom, $urandom} % d);
  endfunction

  initial begin
    rsp_t   z;
    row_t   rw;
    req_t   r;
    int     sent, n;
    vals_t  va, vb;
    errors    = 0;
    key_cnt   = 0;
    hold_rx   = 1'b0;
    no_gaps   = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    z         = pack_rsp(ST_OK, '0, '0);

    // Directed rows: typed where the answer is obvious
    rw.typed = 1; rw.item = make_req(ACT_QUERY, 64'd5, 32'h0, 32'h0);
    rw.want = pack_rsp(ST_EMPTY, '0, '0); add_row(rw);
    rw.item = make_req(ACT_UNKNOWN, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    rw.want = z; add_row(rw);
    rw.item = make_req(ACT_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'h8000_0000);
    rw.want = z; add_row(rw);
    va = req_vals(rw.item);
    rw.item = make_req(ACT_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    rw.want = z; add_row(rw);
    vb = req_vals(rw.item);
    rw.item = make_req(ACT_QUERY, 64'h8000_0000_0000_0000, '0, '0);
    rw.want = pack_rsp(ST_OK, 64'h8000_0000_0000_0000, va); add_row(rw);
    rw.item = make_req(ACT_QUERY, 64'h7fff_ffff_ffff_ffff, '0, '0);
    rw.want = pack_rsp(ST_OK, 64'h7fff_ffff_ffff_ffff, vb); add_row(rw);
    rw.item = make_req(ACT_INSERT, 64'd0, 32'h0001_2345, 32'd22937600);
    rw.want = z; add_row(rw);
    rw.item = make_req(ACT_INSERT, 64'd100, 32'hfff0_0000, 32'd655360);
    rw.want = z; add_row(rw);
    rw.typed = 0;
    rw.item = make_req(ACT_QUERY, 64'd50, '0, '0); add_row(rw);
    rw.item = make_req(ACT_QUERY, 64'd1, '0, '0); add_row(rw);
    rw.item = make_req(ACT_QUERY, 64'd0, '0, '0); add_row(rw);
    rw.item = make_req(ACT_QUERY, -64'sd5, '0, '0); add_row(rw);
    rw.item = make_req(ACT_QUERY, 64'd1000, '0, '0); add_row(rw);
    rw.item = make_req(ACT_INSERT, 64'd0, 32'h5555_aaaa, -32'sd23592960); add_row(rw);
    rw.item = make_req(ACT_QUERY, 64'd33, '0, '0); add_row(rw);
    rw.typed = 1;
    rw.item = make_req(ACT_CLEAR, '0, '0, '0); rw.want = z; add_row(rw);
    rw.item = make_req(ACT_QUERY, 64'd50, '0, '0);
    rw.want = pack_rsp(ST_EMPTY, '0, '0); add_row(rw);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);

    // Random episodes: clear, fill, overwrite one stamp, then mostly queries
    sent = 0;
    while (sent < RAND_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (sent > 300 && sent < 400) hold_rx = 1'b1;
      send(make_req(ACT_CLEAR, rand_time(), $urandom, $urandom), 0, z);
      n = ($urandom_range(0, 5) == 0) ? 70 : $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        send(rand_req(ACT_INSERT, rand_time()), 0, z);
        sent++;
      end
      // Overwrite at an existing stamp, possibly with the table full
      if (key_cnt > 0) begin
        send(rand_req(ACT_INSERT, key_time[$urandom_range(0, key_cnt - 1)]), 0, z);
        sent++;
      end
      n = $urandom_range(5, 25);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: r = rand_req(ACT_INSERT, rand_time());
          1: r = rand_req(ACT_UNKNOWN, {$urandom, $urandom});
          default: r = rand_req(ACT_QUERY, query_time());
        endcase
        send(r, 0, z);
        sent++;
      end
      // Let the pipeline drain now and then
      if ($urandom_range(0, 4) == 0) begin
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
      end
    end

    req_valid <= 1'b0;
    no_gaps   = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
